/* hdl/f2i_pkg.sv */
// ----------------------------------------------------------------------------
// Float-to-integer conversion package
// Shared types for the decode, shift and saturation stages.
// ----------------------------------------------------------------------------
package f2i_pkg;

  localparam logic [1:0] FMT_HALF   = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;
  localparam logic [1:0] DW_16      = 2'd0;
  localparam logic [1:0] DW_32      = 2'd1;
  localparam logic [1:0] RND_EVEN   = 2'd0;
  localparam logic [1:0] RND_FLOOR  = 2'd1;
  localparam logic [1:0] RND_CEIL   = 2'd2;

  // Decoded operand: value is mant * 2^expo.
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               neg;
    logic [52:0]        mant;
    logic signed [12:0] expo;
    logic               src64;
    logic [1:0]         dw;
    logic               sgn;
    logic [1:0]         rmode;
  } dec_t;

  // Rounded magnitude and flags for the saturation stage.
  typedef struct packed {
    logic        nan;
    logic        over;
    logic        neg;
    logic [63:0] mag;
    logic        src64;
    logic [1:0]  dw;
    logic        sgn;
  } mag_t;

endpackage

/* hdl/float_to_int_converter.sv */
// ----------------------------------------------------------------------------
// Float-to-integer converter
// Converts half, single or double floats to saturated 16/32/64-bit integers.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one float operand and
// its conversion controls per transfer; the output channel (out_valid,
// out_stall) returns one integer result per input transfer, in order.
// The work runs in three register stages: decode, align and round, then
// saturate into the output register; each input transfer passes through
// the decode, round and output registers in turn before out_valid rises.
// Throughput is one item per cycle while out_stall is low, set by the
// three stage pipeline with no loops.
// When out_stall is high, each stage holds whose successor is full; empty
// stages keep filling, so in_stall rises only when all three stages hold
// valid data and the output is stalled. No item is lost or repeated.
// Reset clears all stage valid bits; the block then accepts at once.
// ----------------------------------------------------------------------------
module float_to_int_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_source_bits,
  input  logic [1:0]  in_source_format,
  input  logic [1:0]  in_dest_width,
  input  logic        in_signed_result,
  input  logic [1:0]  in_rounding_mode,
  input  logic        in_take_absolute,
  input  logic        in_negate_operand,
  input  logic        in_flush_denormals,
  input  logic        in_upper_half,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_value,
  output logic        out_result_is_wide
);

  f2i_pkg::dec_t dec_nxt, dec_r;
  f2i_pkg::mag_t mag_nxt, mag_r;
  logic [63:0]   val_nxt, val_r;
  logic          wide_nxt, wide_r;
  logic          v1_r, v2_r, v3_r;
  logic          en1, en2, en3;

  assign en3 = !v3_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  f2i_decode u_dec (
    .source_bits     (in_source_bits),
    .source_format   (in_source_format),
    .dest_width      (in_dest_width),
    .signed_result   (in_signed_result),
    .rounding_mode   (in_rounding_mode),
    .take_absolute   (in_take_absolute),
    .negate_operand  (in_negate_operand),
    .flush_denormals (in_flush_denormals),
    .upper_half      (in_upper_half),
    .dec             (dec_nxt)
  );

  f2i_round u_rnd (
    .dec (dec_r),
    .mo  (mag_nxt)
  );

  f2i_saturate u_sat (
    .mi             (mag_r),
    .result_value   (val_nxt),
    .result_is_wide (wide_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) dec_r <= dec_nxt;
    if (en2) mag_r <= mag_nxt;
    if (en3) begin
      val_r  <= val_nxt;
      wide_r <= wide_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_result_value = val_r;
  assign out_result_is_wide = wide_r;

endmodule

/* hdl/f2i_decode.sv */
// ----------------------------------------------------------------------------
// Float-to-integer decode
// Unpacks the selected float format and applies absolute, negate and the single-format denormal flush.
// ----------------------------------------------------------------------------
module f2i_decode (
  input  logic [63:0]     source_bits,
  input  logic [1:0]      source_format,
  input  logic [1:0]      dest_width,
  input  logic            signed_result,
  input  logic [1:0]      rounding_mode,
  input  logic            take_absolute,
  input  logic            negate_operand,
  input  logic            flush_denormals,
  input  logic            upper_half,
  output f2i_pkg::dec_t   dec
);

  logic [15:0]  h;
  logic         s;
  logic [10:0]  ex;
  logic [51:0]  fr;
  logic         exmax;
  logic         exzero;
  logic         ftz;
  logic signed [12:0] bias;

  always_comb begin
    h = upper_half ? source_bits[31:16] : source_bits[15:0];
    ftz = 1'b0;
    if (source_format == f2i_pkg::FMT_HALF) begin
      s = h[15];
      ex = {6'd0, h[14:10]};
      fr = {42'd0, h[9:0]};
      exmax = &h[14:10];
      bias = 13'sd25;
    end else if (source_format == f2i_pkg::FMT_SINGLE) begin
      s = source_bits[31];
      ex = {3'd0, source_bits[30:23]};
      fr = {29'd0, source_bits[22:0]};
      exmax = &source_bits[30:23];
      bias = 13'sd150;
      ftz = flush_denormals && !dest_width[1];
    end else begin
      s = source_bits[63];
      ex = source_bits[62:52];
      fr = source_bits[51:0];
      exmax = &source_bits[62:52];
      bias = 13'sd1075;
    end
    exzero = (ex == 11'd0);
    dec.nan = exmax && (fr != 52'd0);
    dec.inf = exmax && (fr == 52'd0);
    if (exmax) begin
      dec.mant = 53'd0;
      dec.expo = 13'sd0;
    end else if (exzero) begin
      dec.mant = ftz ? 53'd0 : {1'b0, fr};
      dec.expo = 13'sd1 - bias;
    end else begin
      if (source_format == f2i_pkg::FMT_HALF) dec.mant = {42'd0, 1'b1, fr[9:0]};
      else if (source_format == f2i_pkg::FMT_SINGLE) dec.mant = {29'd0, 1'b1, fr[22:0]};
      else dec.mant = {1'b1, fr};
      dec.expo = $signed({2'b00, ex}) - bias;
    end
    dec.neg = (s && !take_absolute) ^ negate_operand;
    dec.src64 = source_format[1];
    dec.dw = dest_width;
    dec.sgn = signed_result;
    dec.rmode = rounding_mode;
  end

endmodule

/* hdl/f2i_round.sv */
// ----------------------------------------------------------------------------
// Float-to-integer alignment and rounding
// Shifts the mantissa to an integer and applies the rounding mode.
// ----------------------------------------------------------------------------
module f2i_round (
  input  f2i_pkg::dec_t dec,
  output f2i_pkg::mag_t mo
);

  logic [116:0] wide;
  logic [63:0]  ip;
  logic         half_bit;
  logic         sticky;
  logic         up;
  logic [6:0]   sh;
  logic [5:0]   lsh;

  always_comb begin
    mo.nan = dec.nan;
    mo.neg = dec.neg;
    mo.src64 = dec.src64;
    mo.dw = dec.dw;
    mo.sgn = dec.sgn;
    mo.over = dec.inf;
    mo.mag = 64'd0;
    wide = '0;
    ip = '0;
    half_bit = 1'b0;
    sticky = 1'b0;
    up = 1'b0;
    sh = '0;
    lsh = '0;
    if (dec.inf || dec.nan) begin
      mo.mag = 64'd0;
    end else if (!dec.expo[12]) begin
      if (dec.expo >= 13'sd64) begin
        mo.over = (dec.mant != 53'd0);
      end else begin
        lsh = dec.expo[5:0];
        wide = {64'd0, dec.mant} << lsh;
        mo.over = (wide[116:64] != 53'd0);
        mo.mag = wide[63:0];
      end
    end else begin
      if (dec.expo < -13'sd64) begin
        sh = 7'd64;
        ip = 64'd0;
        half_bit = 1'b0;
        sticky = (dec.mant != 53'd0);
      end else begin
        sh = 7'(-dec.expo);
        wide = {dec.mant, 64'd0} >> sh;
        ip = {11'd0, wide[116:64]};
        half_bit = wide[63];
        sticky = (wide[62:0] != 63'd0);
      end
      if (half_bit || sticky) begin
        case (dec.rmode)
          f2i_pkg::RND_EVEN:  up = half_bit && (sticky || ip[0]);
          f2i_pkg::RND_FLOOR: up = dec.neg;
          f2i_pkg::RND_CEIL:  up = !dec.neg;
          default:            up = 1'b0;
        endcase
      end
      mo.mag = ip + {63'd0, up};
    end
  end

endmodule

/* hdl/f2i_saturate.sv */
// ----------------------------------------------------------------------------
// Float-to-integer saturation
// Clamps the magnitude to the destination range and forms the result.
// ----------------------------------------------------------------------------
module f2i_saturate (
  input  f2i_pkg::mag_t mi,
  output logic [63:0]   result_value,
  output logic          result_is_wide
);

  logic        dst64;
  logic [63:0] lim;
  logic [63:0] res;
  logic [63:0] mag;

  always_comb begin
    dst64 = mi.dw[1];
    mag = mi.mag;
    res = 64'd0;
    if (mi.sgn) begin
      lim = (mi.dw == f2i_pkg::DW_16) ? 64'h8000 :
            (mi.dw == f2i_pkg::DW_32) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
      if (mi.neg) begin
        if (mi.over || mag > lim) mag = lim;
        res = ~mag + 64'd1;
      end else begin
        if (mi.over || mag > lim - 64'd1) mag = lim - 64'd1;
        res = mag;
      end
    end else begin
      lim = (mi.dw == f2i_pkg::DW_16) ? 64'hFFFF :
            (mi.dw == f2i_pkg::DW_32) ? 64'hFFFF_FFFF : '1;
      if (mi.neg) res = 64'd0;
      else if (mi.over || mag > lim) res = lim;
      else res = mag;
    end
    if (mi.nan) begin
      res = 64'd0;
      if ((mi.src64 != dst64) && (mi.dw != f2i_pkg::DW_16))
        res = dst64 ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    end
    result_value = dst64 ? res : {32'd0, res[31:0]};
    result_is_wide = dst64;
  end

endmodule
